// File: src/address_window_table_mapper_core_assert.svh
// assertion macros for the address window table mapper
`ifndef ADDRESS_WINDOW_TABLE_MAPPER_CORE_ASSERT_SVH
`define ADDRESS_WINDOW_TABLE_MAPPER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define AWTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define AWTM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define AWTM_ASSERT(lbl, prop, msg)
`define AWTM_NEVER(lbl, expr, msg)
`endif
`endif

// File: src/awtm_pkg.sv
package awtm_pkg;

    localparam int AWTM_ENTRIES = 16;

    // request codes
    localparam logic [1:0] OP_ACTIVE = 2'd0;
    localparam logic [1:0] OP_MAP    = 2'd1;
    localparam logic [1:0] OP_UNMAP  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_VERSION   = 3'd0;
    localparam logic [2:0] REG_ADDR_SH   = 3'd1;
    localparam logic [2:0] REG_SIZE_SH   = 3'd2;
    localparam logic [2:0] REG_SIZE_LIM  = 3'd3;
    localparam logic [2:0] REG_FLAGS_MSK = 3'd4;
    localparam logic [2:0] REG_EXCL_END  = 3'd5;
    localparam logic [2:0] REG_PROT      = 3'd6;
    localparam logic [2:0] REG_GUARD_EN  = 3'd7;

    localparam logic [1:0] VER_SPLIT = 2'd3;
    localparam logic [1:0] VER_WIDE  = 2'd2;

    // request and settings broadcast to every cell
    typedef struct packed {
        logic        is_map;
        logic [63:0] addr;
        logic [63:0] length;
        logic [1:0]  version;
        logic [4:0]  addr_shift;
        logic [4:0]  len_shift;
        logic        excl_end;
        logic [15:0] prot;
    } req_t;

    // entry update broadcast to the cells
    typedef struct packed {
        logic        map_we;
        logic        words_clr;
        logic        shadow_clr;
        logic        size_we;
        logic [31:0] cfg_word;
        logic [31:0] addr_word;
        logic [31:0] size_word;
        logic [63:0] base;
        logic [63:0] length;
        logic [7:0]  flags;
        logic        guard;
    } wr_t;

endpackage

// File: src/awtm_cell.sv
module awtm_cell
    import awtm_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  req_t             req,
    input  wr_t              wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic             tok_in_valid,
    input  logic             tok_in_found,
    input  logic [IDX_W-1:0] tok_in_idx,
    output logic             tok_out_valid,
    output logic             tok_out_found,
    output logic [IDX_W-1:0] tok_out_idx,
    output logic             guard_bit
);

    logic [63:0] sh_base_reg;
    logic [63:0] sh_len_reg;
    logic [7:0]  sh_flags_reg;
    logic        sh_guard_reg;
    logic [31:0] cfg_word_reg;
    logic [31:0] addr_word_reg;
    logic [31:0] size_word_reg;
    logic             tok_valid_reg;
    logic             tok_found_reg;
    logic [IDX_W-1:0] tok_idx_reg;

    logic [7:0]  dec_flags;
    logic [31:0] dec_raw;
    logic [31:0] raw_adj;
    logic [63:0] dec_base;
    logic [63:0] dec_len;
    logic [15:0] prot_sh;
    logic        prot_bit;
    logic        hit;
    logic        sel;

    // decode the hardware words under the current version
    always_comb begin
        unique case (req.version)
            VER_SPLIT: begin
                dec_flags = cfg_word_reg[7:0];
                dec_raw   = size_word_reg;
            end
            VER_WIDE: begin
                dec_flags = cfg_word_reg[31:24];
                dec_raw   = {8'h0, cfg_word_reg[23:0]};
            end
            default: begin
                dec_flags = {3'h0, cfg_word_reg[28:24]};
                dec_raw   = {13'h0, cfg_word_reg[18:0]};
            end
        endcase
        raw_adj  = dec_raw + {31'h0, (dec_flags != 8'h0) && !req.excl_end};
        dec_base = {32'h0, addr_word_reg} << req.addr_shift;
        dec_len  = {32'h0, raw_adj} << req.len_shift;
    end

    // free or matching test for the passing request
    always_comb begin
        prot_sh  = req.prot >> INDEX;
        prot_bit = prot_sh[0];
        if (req.is_map) begin
            hit = !prot_bit && (sh_flags_reg == 8'h0) && (dec_flags == 8'h0);
        end else if (sh_flags_reg != 8'h0) begin
            hit = (sh_base_reg == req.addr) && (sh_len_reg == req.length);
        end else begin
            hit = (dec_flags != 8'h0) && (dec_base == req.addr) && (dec_len == req.length);
        end
    end

    assign sel = (wr_idx == IDX_W'(INDEX));

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
            tok_found_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in_valid;
            tok_found_reg <= tok_in_found || (tok_in_valid && hit);
        end
        tok_idx_reg <= tok_in_found ? tok_in_idx : IDX_W'(INDEX);
    end

    // entry state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_base_reg   <= 64'h0;
            sh_len_reg    <= 64'h0;
            sh_flags_reg  <= 8'h0;
            sh_guard_reg  <= 1'b0;
            cfg_word_reg  <= 32'h0;
            addr_word_reg <= 32'h0;
            size_word_reg <= 32'h0;
        end else if (sel) begin
            if (wr.map_we) begin
                sh_base_reg   <= wr.base;
                sh_len_reg    <= wr.length;
                sh_flags_reg  <= wr.flags;
                sh_guard_reg  <= wr.guard;
                cfg_word_reg  <= wr.cfg_word;
                addr_word_reg <= wr.addr_word;
                if (wr.size_we) begin
                    size_word_reg <= wr.size_word;
                end
            end
            if (wr.words_clr) begin
                cfg_word_reg  <= 32'h0;
                addr_word_reg <= 32'h0;
                if (wr.size_we) begin
                    size_word_reg <= 32'h0;
                end
            end
            if (wr.shadow_clr) begin
                sh_base_reg  <= 64'h0;
                sh_len_reg   <= 64'h0;
                sh_flags_reg <= 8'h0;
                sh_guard_reg <= 1'b0;
            end
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_found = tok_found_reg;
    assign tok_out_idx   = tok_idx_reg;
    assign guard_bit     = sh_guard_reg;

endmodule

// File: src/address_window_table_mapper_core.sv
// channel  | ports                                        | direction
// s_       | s_op s_addr s_length s_perm s_guarded        | in, valid/ready
// m_       | m_status m_entry_index m_*_word m_active     | out, valid/ready
// cfg_     | cfg_we cfg_addr cfg_wdata                    | in, write only
// a map or unmap item goes from accept to result through capture, range check,
// a search token walking the row of entry cells one cell a cycle, commit and
// output load; other ops skip the walk
// synchronous active-low reset clears all entries, the guard count and flag
// a stalled result holds in the output register; the next item is taken meanwhile
module address_window_table_mapper_core
    import awtm_pkg::*;
#(
    parameter int ENTRIES = AWTM_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_addr,
    input  logic [63:0] s_length,
    input  logic [1:0]  s_perm,
    input  logic [1:0]  s_guarded,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [3:0]  m_entry_index,
    output logic [31:0] m_config_word,
    output logic [31:0] m_addr_word,
    output logic [31:0] m_size_word,
    output logic        m_active
);

`include "address_window_table_mapper_core_assert.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_COMMIT, ST_DONE} state_t;

    state_t state_reg;

    // configuration registers
    logic [1:0]  version_reg;
    logic [4:0]  addr_shift_reg;
    logic [4:0]  len_shift_reg;
    logic [31:0] size_limit_reg;
    logic [7:0]  flags_mask_reg;
    logic        excl_end_reg;
    logic [15:0] prot_reg;
    logic        guard_en_reg;

    // request
    logic [1:0]  op_reg;
    logic [63:0] addr_reg;
    logic [63:0] len_reg;
    logic [1:0]  perm_reg;
    logic [1:0]  guarded_reg;
    logic        range_ok_reg;
    logic [31:0] araw_reg;
    logic [31:0] raw_reg;
    logic        launch_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;

    logic [4:0]  guard_cnt_reg;
    logic [4:0]  guard_cnt_next;
    logic        active_reg;
    logic        active_next;

    // result held between commit and output load
    logic        res_st_reg;
    logic [3:0]  res_idx_reg;
    logic [31:0] res_cw_reg;
    logic [31:0] res_aw_reg;
    logic [31:0] res_sw_reg;

    logic        m_valid_reg;
    logic        m_status_reg;
    logic [3:0]  m_idx_reg;
    logic [31:0] m_cw_reg;
    logic [31:0] m_aw_reg;
    logic [31:0] m_sw_reg;
    logic        m_active_reg;

    req_t req;
    wr_t  wr;

    logic [ENTRIES:0]   tok_v;
    logic [ENTRIES:0]   tok_f;
    logic [IDX_W-1:0]   tok_i [ENTRIES+1];
    logic [ENTRIES-1:0] guard_vec;

    // range check terms
    logic [63:0] am;
    logic [63:0] sm;
    logic [64:0] sum;
    logic [63:0] nsh;
    logic        range_ok;

    always_comb begin
        am  = (64'h1 << addr_shift_reg) - 64'h1;
        sm  = (64'h1 << len_shift_reg) - 64'h1;
        sum = {1'b0, addr_reg} + {1'b0, len_reg};
        nsh = len_reg >> len_shift_reg;
        range_ok = (len_reg != 64'h0) && ((len_reg & sm) == 64'h0)
                && ((addr_reg & am) == 64'h0) && !sum[64]
                && (nsh[63:32] == 32'h0) && (nsh[31:0] <= size_limit_reg);
    end

    // broadcast to the cell row
    always_comb begin
        req.is_map     = (op_reg == OP_MAP);
        req.addr       = addr_reg;
        req.length     = len_reg;
        req.version    = version_reg;
        req.addr_shift = addr_shift_reg;
        req.len_shift  = len_shift_reg;
        req.excl_end   = excl_end_reg;
        req.prot       = prot_reg;
    end

    assign tok_v[0] = launch_reg;
    assign tok_f[0] = 1'b0;
    assign tok_i[0] = '0;

    // row of entry cells
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        awtm_cell #(
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .req           (req),
            .wr            (wr),
            .wr_idx        (found_idx_reg),
            .tok_in_valid  (tok_v[k]),
            .tok_in_found  (tok_f[k]),
            .tok_in_idx    (tok_i[k]),
            .tok_out_valid (tok_v[k+1]),
            .tok_out_found (tok_f[k+1]),
            .tok_out_idx   (tok_i[k+1]),
            .guard_bit     (guard_vec[k])
        );
    end

    // commit decision
    logic [7:0]       flags;
    logic [7:0]       fm;
    logic [31:0]      rawst;
    logic [31:0]      cfgw;
    logic [4:0]       gc_inc;
    logic [15:0]      prot_sh;
    logic             sel_prot;
    logic             st;
    logic [3:0]       idx_o;
    logic [31:0]      cw_o;
    logic [31:0]      aw_o;
    logic [31:0]      sw_o;
    logic [IDX_W+3:0] idx_ext;

    always_comb begin
        flags    = (version_reg == VER_WIDE || version_reg == VER_SPLIT)
                 ? (perm_reg[0] ? 8'hff : 8'hea) : flags_mask_reg;
        fm       = flags & flags_mask_reg;
        rawst    = excl_end_reg ? raw_reg : raw_reg - 32'h1;
        cfgw     = (version_reg == VER_SPLIT) ? {24'h0, fm} : ({fm, 24'h0} | rawst);
        gc_inc   = guard_cnt_reg + 5'h1;
        prot_sh  = prot_reg >> found_idx_reg;
        sel_prot = prot_sh[0] && (32'(found_idx_reg) < 32'd16);
        idx_ext  = {4'h0, found_idx_reg};

        st             = 1'b1;
        idx_o          = 4'h0;
        cw_o           = 32'h0;
        aw_o           = 32'h0;
        sw_o           = 32'h0;
        guard_cnt_next = guard_cnt_reg;
        active_next    = active_reg;

        wr            = '0;
        wr.cfg_word   = cfgw;
        wr.addr_word  = araw_reg;
        wr.size_word  = rawst;
        wr.base       = addr_reg;
        wr.length     = len_reg;
        wr.flags      = flags;
        wr.guard      = guarded_reg[0];
        wr.size_we    = (version_reg == VER_SPLIT);

        if (state_reg == ST_COMMIT) begin
            unique case (op_reg)
                OP_ACTIVE: begin
                    active_next = addr_reg[0];
                    st          = 1'b0;
                end
                OP_MAP: begin
                    if (range_ok_reg && !perm_reg[1] && !guarded_reg[1]
                            && (flags != 8'h0) && found_reg) begin
                        if (guarded_reg[0] && guard_en_reg) begin
                            guard_cnt_next = gc_inc;
                        end
                        if (!(guarded_reg[0] && guard_en_reg && gc_inc == 5'h0)) begin
                            wr.map_we = 1'b1;
                            st        = 1'b0;
                            idx_o     = idx_ext[3:0];
                            cw_o      = cfgw;
                            aw_o      = araw_reg;
                            sw_o      = (version_reg == VER_SPLIT) ? rawst : 32'h0;
                        end
                    end
                end
                OP_UNMAP: begin
                    if (range_ok_reg && found_reg) begin
                        idx_o = idx_ext[3:0];
                        st    = 1'b0;
                        if (!sel_prot) begin
                            wr.words_clr = 1'b1;
                            if (guard_vec[found_idx_reg] && guard_en_reg) begin
                                if (guard_cnt_reg == 5'h0) begin
                                    st = 1'b1;
                                end else begin
                                    guard_cnt_next = guard_cnt_reg - 5'h1;
                                    wr.shadow_clr  = 1'b1;
                                end
                            end else begin
                                wr.shadow_clr = 1'b1;
                            end
                        end
                    end
                end
                default: st = 1'b1;
            endcase
            if (st) begin
                idx_o = 4'h0;
                cw_o  = 32'h0;
                aw_o  = 32'h0;
                sw_o  = 32'h0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg    <= 2'd2;
            addr_shift_reg <= 5'd12;
            len_shift_reg  <= 5'd12;
            size_limit_reg <= 32'd524287;
            flags_mask_reg <= 8'hff;
            excl_end_reg   <= 1'b0;
            prot_reg       <= 16'h0;
            guard_en_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_VERSION:   version_reg    <= cfg_wdata[1:0];
                REG_ADDR_SH:   addr_shift_reg <= cfg_wdata[4:0];
                REG_SIZE_SH:   len_shift_reg  <= cfg_wdata[4:0];
                REG_SIZE_LIM:  size_limit_reg <= cfg_wdata;
                REG_FLAGS_MSK: flags_mask_reg <= cfg_wdata[7:0];
                REG_EXCL_END:  excl_end_reg   <= cfg_wdata[0];
                REG_PROT:      prot_reg       <= cfg_wdata[15:0];
                REG_GUARD_EN:  guard_en_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            guard_cnt_reg <= 5'h0;
            active_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            launch_reg    <= 1'b0;
            guard_cnt_reg <= guard_cnt_next;
            active_reg    <= active_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (op_reg == OP_MAP || op_reg == OP_UNMAP) begin
                        launch_reg <= 1'b1;
                        state_reg  <= ST_SCAN;
                    end else begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_SCAN: begin
                    if (tok_v[ENTRIES]) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_status_reg <= res_st_reg;
                        m_idx_reg    <= res_idx_reg;
                        m_cw_reg     <= res_cw_reg;
                        m_aw_reg     <= res_aw_reg;
                        m_sw_reg     <= res_sw_reg;
                        m_active_reg <= active_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg      <= s_op;
            addr_reg    <= s_addr;
            len_reg     <= s_length;
            perm_reg    <= s_perm;
            guarded_reg <= s_guarded;
        end
        if (state_reg == ST_CHECK) begin
            range_ok_reg <= range_ok;
            araw_reg     <= 32'(addr_reg >> addr_shift_reg);
            raw_reg      <= nsh[31:0];
        end
        if (state_reg == ST_SCAN && tok_v[ENTRIES]) begin
            found_reg     <= tok_f[ENTRIES];
            found_idx_reg <= tok_i[ENTRIES];
        end
        if (state_reg == ST_COMMIT) begin
            res_st_reg  <= st;
            res_idx_reg <= idx_o;
            res_cw_reg  <= cw_o;
            res_aw_reg  <= aw_o;
            res_sw_reg  <= sw_o;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_idx_reg;
    assign m_config_word = m_cw_reg;
    assign m_addr_word   = m_aw_reg;
    assign m_size_word   = m_sw_reg;
    assign m_active      = m_active_reg;

    // checks
    `AWTM_ASSERT(a_guard_only_commit, (state_reg != ST_COMMIT) |=> $stable(guard_cnt_reg), "guard moved")
    `AWTM_ASSERT(a_token_in_scan, tok_v[ENTRIES] |-> (state_reg == ST_SCAN), "token outside scan")
    `AWTM_ASSERT(a_result_from_done, $rose(m_valid) |-> $past(state_reg == ST_DONE), "stray result")

endmodule
